### hdl/dsr_pkg.sv
// Package for the datagram sequence reassembly block.
// Holds the field widths, the verdict codes, the item and result types.
// No dependencies.
package dsr_pkg;

  localparam int unsigned SEQ_W      = 31;
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned PAYLOAD_W  = 11;
  localparam int unsigned CAP_W      = 16;

  localparam logic [LEN_W-1:0] FULL_FRAG_BYTES  = 15'd1300;
  localparam logic [CAP_W-1:0] REASSEMBLY_BYTES = 16'd16384;
  localparam logic [CAP_W-1:0] CAPACITY_RESET   = 16'd16384;

  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_DONE    = 3'd1,
    V_STALE   = 3'd2,
    V_MISSING = 3'd3,
    V_BADLEN  = 3'd4,
    V_PENDING = 3'd5,
    V_TOOBIG  = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [31:0]          seq_word;
    logic signed [15:0]   frag_start;
    logic signed [15:0]   frag_length;
    logic [PAYLOAD_W-1:0] payload_bytes;
  } item_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [SEQ_W-1:0] sequence_res;
    logic [SEQ_W-1:0] dropped_count;
    logic [LEN_W-1:0] write_offset;
    logic [LEN_W-1:0] message_length;
  } result_t;

endpackage

### hdl/dsr_if.sv
// Valid/ready channel interfaces for the header input and the verdict output.
// Depend on dsr_pkg for the field widths and the verdict type.
interface dsr_in_if import dsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [31:0]          seq_word;
  logic signed [15:0]   frag_start;
  logic signed [15:0]   frag_length;
  logic [PAYLOAD_W-1:0] payload_bytes;

  modport source(output valid, seq_word, frag_start, frag_length, payload_bytes,
                 input ready);
  modport sink(input valid, seq_word, frag_start, frag_length, payload_bytes,
               output ready);
endinterface

interface dsr_out_if import dsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       verdict;
  logic [SEQ_W-1:0] sequence_res;
  logic [SEQ_W-1:0] dropped_count;
  logic [LEN_W-1:0] write_offset;
  logic [LEN_W-1:0] message_length;

  modport source(output valid, verdict, sequence_res, dropped_count, write_offset,
                 message_length, input ready);
  modport sink(input valid, verdict, sequence_res, dropped_count, write_offset,
               message_length, output ready);
endinterface

### hdl/dsr_verdict.sv
// Verdict logic and sequence/fill state for one header item.
// Depends on dsr_pkg. State advances when the top level moves the item on.
module dsr_verdict import dsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  item_t            item,
  input  logic [CAP_W-1:0] capacity,
  output result_t          res
);

  logic [SEQ_W-1:0] inc_seq_r, inc_seq_nxt;
  logic [SEQ_W-1:0] frag_seq_r, frag_seq_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;

  logic             frag;
  logic [SEQ_W-1:0] seq;
  logic             stale;
  logic [LEN_W-1:0] fill_cur;
  logic             start_ok;
  logic             len_neg;
  logic [LEN_W-1:0] flen_u;
  logic             len_bad;
  logic [CAP_W-1:0] sum;
  logic [LEN_W-1:0] sum_len;
  logic             pending;
  logic             too_big;
  logic [SEQ_W-1:0] diff;

  // Decode the item against the current state
  always_comb begin
    frag     = item.seq_word[31];
    seq      = item.seq_word[SEQ_W-1:0];
    stale    = (seq <= inc_seq_r);
    fill_cur = (frag && (seq != frag_seq_r)) ? '0 : fill_r;
    start_ok = !item.frag_start[15] && (item.frag_start[14:0] == fill_cur);
    len_neg  = item.frag_length[15];
    flen_u   = item.frag_length[14:0];
    sum      = {1'b0, fill_cur} + {1'b0, flen_u};
    sum_len  = sum[LEN_W-1:0];
    len_bad  = len_neg || (flen_u > {4'b0, item.payload_bytes}) ||
               (sum > REASSEMBLY_BYTES);
    pending  = (flen_u == FULL_FRAG_BYTES);
    too_big  = ({1'b0, sum_len} > capacity);
    diff     = seq - inc_seq_r - 1'b1;
  end

  // Pick the verdict, the result fields and the next state
  always_comb begin
    inc_seq_nxt        = inc_seq_r;
    frag_seq_nxt       = frag_seq_r;
    fill_nxt           = fill_r;
    res.sequence_res   = seq;
    res.dropped_count  = '0;
    res.write_offset   = '0;
    res.message_length = {4'b0, item.payload_bytes};
    res.verdict        = V_STALE;
    if (!stale) begin
      res.dropped_count = diff;
      if (!frag) begin
        res.verdict = V_ACCEPT;
        inc_seq_nxt = seq;
      end else begin
        frag_seq_nxt       = seq;
        fill_nxt           = fill_cur;
        res.write_offset   = fill_cur;
        res.message_length = len_neg ? '0 : flen_u;
        priority if (!start_ok) begin
          res.verdict = V_MISSING;
        end else if (len_bad) begin
          res.verdict = V_BADLEN;
        end else if (pending) begin
          res.verdict = V_PENDING;
          fill_nxt    = sum_len;
        end else if (too_big) begin
          res.verdict = V_TOOBIG;
          fill_nxt    = sum_len;
        end else begin
          res.verdict        = V_DONE;
          res.message_length = sum_len;
          fill_nxt           = '0;
          inc_seq_nxt        = seq;
        end
      end
    end
  end

  // Commit state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_seq_r  <= '0;
      frag_seq_r <= '0;
      fill_r     <= '0;
    end else if (adv) begin
      inc_seq_r  <= inc_seq_nxt;
      frag_seq_r <= frag_seq_nxt;
      fill_r     <= fill_nxt;
    end
  end

endmodule

### hdl/datagram_sequence_reassembly.sv
// Top level of the datagram sequence reassembly block.
// Depends on dsr_pkg, dsr_if (channel interfaces) and dsr_verdict.
//
// Usage: each item on in_ch is one parsed datagram header (sequence word,
// fragment start, fragment length, payload bytes). For each item exactly one
// result leaves on out_ch: a verdict plus sequence, dropped count, write
// offset and message length. cfg_we/cfg_wdata write the message capacity;
// write it only while the block is idle.
// Each taken item first sits in the input register, where the verdict logic
// reads the sequence/fill state, and then in the result register, which
// offers it on out_ch and raises out_ch.valid. Throughput is one item per cycle
// while the receiver does not stall; the state update of one item is already
// visible to the next item.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both registers, clears the sequence
// and fill state and sets the capacity to 16384.
module datagram_sequence_reassembly import dsr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  dsr_in_if.sink          in_ch,
  dsr_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic             in_v_r;
  item_t            in_r;
  logic             out_v_r;
  result_t          out_r;
  result_t          res;
  logic [CAP_W-1:0] capacity_r;
  logic             adv;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // Input register: load on accept, empty when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.seq_word      <= in_ch.seq_word;
      in_r.frag_start    <= in_ch.frag_start;
      in_r.frag_length   <= in_ch.frag_length;
      in_r.payload_bytes <= in_ch.payload_bytes;
    end
  end

  dsr_verdict u_verdict (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (in_r),
    .capacity (capacity_r),
    .res      (res)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.verdict        = out_r.verdict;
  assign out_ch.sequence_res   = out_r.sequence_res;
  assign out_ch.dropped_count  = out_r.dropped_count;
  assign out_ch.write_offset   = out_r.write_offset;
  assign out_ch.message_length = out_r.message_length;

endmodule

### tb/dsr_result_checker.sv
// Result checker for the datagram sequence reassembly testbench.
// Watches the header and verdict channels and the capacity write port, predicts
// each verdict and compares it. Depends on dsr_pkg and the channel interfaces.
module dsr_result_checker import dsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  dsr_in_if                in_ch,
  dsr_out_if               out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int unsigned      fail_count,
  output int unsigned      pending_count
);

  // Predicted copy of the block's sequence, fill and capacity registers
  logic [SEQ_W-1:0] last_seq;
  logic [SEQ_W-1:0] reasm_seq;
  logic [LEN_W-1:0] fill;
  logic [CAP_W-1:0] capacity;

  result_t     verdict_q[$];
  int unsigned misses;
  int unsigned result_idx;

  // Decide the fate of one header and advance the predicted state
  function automatic result_t judge_header(input item_t hdr);
    result_t          r;
    logic [SEQ_W-1:0] seq;
    int               start_v;
    int               len_v;
    int               sum;
    seq     = hdr.seq_word[SEQ_W-1:0];
    start_v = {{16{hdr.frag_start[15]}}, hdr.frag_start};
    len_v   = {{16{hdr.frag_length[15]}}, hdr.frag_length};
    r.verdict        = V_STALE;
    r.sequence_res   = seq;
    r.dropped_count  = '0;
    r.write_offset   = '0;
    r.message_length = LEN_W'(hdr.payload_bytes);
    if (seq > last_seq) begin
      r.dropped_count = seq - last_seq - 1'b1;
      if (!hdr.seq_word[31]) begin
        last_seq  = seq;
        r.verdict = V_ACCEPT;
      end else begin
        // A new sequence restarts reassembly even if this fragment is rejected
        if (seq != reasm_seq) begin
          reasm_seq = seq;
          fill      = '0;
        end
        r.write_offset   = fill;
        r.message_length = (len_v < 0) ? '0 : LEN_W'(len_v);
        sum = int'(fill) + len_v;
        if (start_v != int'(fill)) begin
          r.verdict = V_MISSING;
        end else if (len_v < 0 || len_v > int'(hdr.payload_bytes) ||
                     sum > int'(REASSEMBLY_BYTES)) begin
          r.verdict = V_BADLEN;
        end else begin
          fill = LEN_W'(sum);
          if (len_v == int'(FULL_FRAG_BYTES)) begin
            r.verdict = V_PENDING;
          end else if (sum > int'(capacity)) begin
            // Oversized message keeps its fill and the last sequence
            r.verdict = V_TOOBIG;
          end else begin
            r.verdict        = V_DONE;
            r.message_length = fill;
            fill             = '0;
            last_seq         = seq;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic log_failure(input string msg);
    misses++;
    if (misses <= 10) $display("%s", msg);
  endtask

  // Retire results first, then queue the prediction for a newly taken item
  always @(posedge clk) begin : watch
    item_t   hdr;
    result_t want;
    result_t got;
    if (!rst_n) begin
      last_seq  = '0;
      reasm_seq = '0;
      fill      = '0;
      capacity  = CAPACITY_RESET;
      verdict_q.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.verdict        = verdict_t'(out_ch.verdict);
        got.sequence_res   = out_ch.sequence_res;
        got.dropped_count  = out_ch.dropped_count;
        got.write_offset   = out_ch.write_offset;
        got.message_length = out_ch.message_length;
        if (verdict_q.size() == 0) begin
          log_failure($sformatf("result %0d arrived with nothing outstanding: verdict %0d seq %0d",
                                result_idx, got.verdict, got.sequence_res));
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict || got.sequence_res !== want.sequence_res ||
              got.dropped_count !== want.dropped_count ||
              got.write_offset !== want.write_offset ||
              got.message_length !== want.message_length) begin
            log_failure($sformatf({"result %0d mismatch: expected verdict %0d seq %0d ",
                                   "dropped %0d offset %0d length %0d, got verdict %0d ",
                                   "seq %0d dropped %0d offset %0d length %0d"},
                                  result_idx, want.verdict, want.sequence_res,
                                  want.dropped_count, want.write_offset,
                                  want.message_length, got.verdict, got.sequence_res,
                                  got.dropped_count, got.write_offset,
                                  got.message_length));
          end
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready) begin
        hdr.seq_word      = in_ch.seq_word;
        hdr.frag_start    = in_ch.frag_start;
        hdr.frag_length   = in_ch.frag_length;
        hdr.payload_bytes = in_ch.payload_bytes;
        verdict_q.push_back(judge_header(hdr));
      end
    end
    pending_count <= verdict_q.size();
    fail_count    <= misses;
  end

endmodule

### tb/datagram_sequence_reassembly_tb.sv
// Testbench top for the datagram sequence reassembly block.
// Drives directed and random datagram headers and capacity writes, with random
// stalls on both channels; dsr_result_checker predicts and compares the verdicts.
module datagram_sequence_reassembly_tb;
  import dsr_pkg::*;

  localparam int FRAG_LEN    = int'(FULL_FRAG_BYTES);
  localparam int HOLD_CYCLES = 300;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int unsigned      fail_count;
  int unsigned      pending_count;

  dsr_in_if  in_ch();
  dsr_out_if out_ch();

  // Stimulus bookkeeping: highest sequence offered, items offered so far, gap and stall odds and the hold-off request
  logic [SEQ_W-1:0] seq_hi;
  int               sent;
  int               src_gap_odds;
  int               sink_stall_odds;
  bit               hold_req;

  datagram_sequence_reassembly dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dsr_result_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Give up well past the slowest legal run
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : sink_side
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_stall_odds > 0 && $urandom_range(0, 15) < sink_stall_odds) begin
        stall = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one header, with an optional idle burst first; hold until taken
  task automatic offer_header(input logic [31:0] word, input int start, input int len,
                              input int pay);
    int gap;
    @(negedge clk);
    if (src_gap_odds > 0 && $urandom_range(0, 15) < src_gap_odds) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.seq_word      <= word;
    in_ch.frag_start    <= 16'(start);
    in_ch.frag_length   <= 16'(len);
    in_ch.payload_bytes <= PAYLOAD_W'(pay);
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Stop offering and wait until every predicted verdict has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Well-formed fragment train with random content, sometimes broken once
  task automatic send_message();
    logic [SEQ_W-1:0] seq;
    int               nfull;
    int               broken;
    int               fill;
    int               len;
    int               pay;
    int               start;
    seq    = seq_hi + SEQ_W'($urandom_range(1, 3));
    seq_hi = seq;
    nfull  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 13) : $urandom_range(0, 3);
    broken = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nfull) : -1;
    fill   = 0;
    for (int i = 0; i <= nfull; i++) begin
      len   = (i < nfull) ? FRAG_LEN : $urandom_range(0, FRAG_LEN - 1);
      pay   = ($urandom_range(0, 7) == 0) ? $urandom_range(len, 2047)
                                          : $urandom_range(len, 1400);
      start = fill;
      if (i == broken) begin
        case ($urandom_range(0, 2))
          0:       start = int'($urandom_range(0, 65535)) - 32768;
          1:       len = -int'($urandom_range(1, 32768));
          default: len = pay + $urandom_range(1, 200);
        endcase
      end
      offer_header({1'b1, seq}, start, len, pay);
      fill += FRAG_LEN;
    end
  endtask

  // Plain datagram with a fresh sequence; fragment fields are don't-care
  task automatic send_plain();
    seq_hi = seq_hi + SEQ_W'($urandom_range(1, 4));
    offer_header({1'b0, seq_hi}, $urandom, $urandom, $urandom_range(0, 2047));
  endtask

  // Random header, stale or fresh, every field free
  task automatic send_noise();
    logic [31:0] word;
    word = $urandom;
    if ($urandom_range(0, 1) != 0)
      word[SEQ_W-1:0] = seq_hi + SEQ_W'($urandom_range(1, 5));
    else
      word[SEQ_W-1:0] = SEQ_W'($urandom % (32'(seq_hi) + 32'd1));
    if (word[SEQ_W-1:0] > seq_hi) seq_hi = word[SEQ_W-1:0];
    offer_header(word, $urandom, $urandom, $urandom_range(0, 2047));
  endtask

  // One random phase: jump the sequence space up, then mix the item kinds
  task automatic run_phase(input int n, input bit pause_midway);
    int target;
    int half;
    int pick;
    bit paused;
    target = sent + n;
    half   = sent + n / 2;
    paused = !pause_midway;
    seq_hi = seq_hi + SEQ_W'($urandom_range(2**28, 2**28 + 2**26));
    while (sent < target) begin
      if (!paused && sent >= half) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) send_message();
      else if (pick < 8) send_plain();
      else send_noise();
    end
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.seq_word      = '0;
    in_ch.frag_start    = '0;
    in_ch.frag_length   = '0;
    in_ch.payload_bytes = '0;
    out_ch.ready        = 1'b0;
    hold_req            = 1'b0;
    seq_hi              = '0;
    sent                = 0;
    src_gap_odds        = 4;
    sink_stall_odds     = 4;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Plain datagrams: stale zero, accept, skipped sequences
    offer_header({1'b0, 31'd0}, 0, 0, 2047);
    offer_header({1'b0, 31'd1}, 0, 0, 0);
    offer_header({1'b0, 31'd5}, 0, 0, 1400);
    // Two-fragment message with out-of-order and bad lengths in between
    offer_header({1'b1, 31'd7}, 0, FRAG_LEN, 1400);
    offer_header({1'b1, 31'd7}, 0, FRAG_LEN, 1400);
    offer_header({1'b1, 31'd7}, FRAG_LEN, -32768, 1400);
    offer_header({1'b1, 31'd7}, FRAG_LEN, 1401, 1400);
    offer_header({1'b1, 31'd7}, FRAG_LEN, 500, 500);
    offer_header({1'b0, 31'd6}, 0, 0, 100);
    // Start and length extremes
    offer_header({1'b1, 31'd9}, -32768, 32767, 2047);
    offer_header({1'b1, 31'd9}, 32767, -1, 0);
    offer_header({1'b1, 31'd9}, 0, 32767, 2047);
    // Fill the store: one fragment too many, then finish at exactly full
    for (int i = 0; i < 12; i++) offer_header({1'b1, 31'd13}, i * FRAG_LEN, FRAG_LEN, 1400);
    offer_header({1'b1, 31'd13}, 12 * FRAG_LEN, FRAG_LEN, FRAG_LEN);
    offer_header({1'b1, 31'd13}, 12 * FRAG_LEN, 784, 784);
    seq_hi = 31'd13;

    // Small capacity: a restart by another sequence, then an oversized message
    write_capacity(16'd1000);
    offer_header({1'b1, 31'd20}, 0, FRAG_LEN, FRAG_LEN);
    offer_header({1'b1, 31'd21}, 5, 5, 5);
    offer_header({1'b1, 31'd20}, 0, FRAG_LEN, FRAG_LEN);
    offer_header({1'b1, 31'd20}, FRAG_LEN, 10, 10);
    seq_hi = 31'd21;

    // Zero capacity, with a long result-side hold-off at the start
    write_capacity(16'd0);
    src_gap_odds    = 3;
    sink_stall_odds = 6;
    hold_req        = 1'b1;
    run_phase(145, 1'b0);

    write_capacity(16'hFFFF);
    src_gap_odds    = 8;
    sink_stall_odds = 2;
    run_phase(145, 1'b1);

    write_capacity(16'd2600);
    src_gap_odds    = 2;
    sink_stall_odds = 8;
    run_phase(145, 1'b0);

    write_capacity(CAP_W'($urandom_range(1, 20000)));
    src_gap_odds    = 5;
    sink_stall_odds = 5;
    run_phase(145, 1'b0);

    // Last part runs back to back on both sides
    write_capacity(16'd16384);
    src_gap_odds    = 0;
    sink_stall_odds = 0;
    run_phase(145, 1'b0);

    // Top of the sequence space, after which everything is stale
    offer_header({1'b1, 31'h7FFF_FFFF}, 0, 7, 7);
    offer_header(32'hFFFF_FFFF, 0, 7, 7);
    offer_header({1'b0, 31'h7FFF_FFFF}, 0, 0, 1400);

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
